@@ rtl/integer_power_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Integer power unit assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_POWER_UNIT_MACROS_SVH
`define INTEGER_POWER_UNIT_MACROS_SVH

// same-cycle implication, masked while in reset
`define IPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while in reset
`define IPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always checked
`define IPU_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ipu_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer power unit package
// Widths and the payload carried through the pipeline.
// ----------------------------------------------------------------------------
package ipu_pkg;

  localparam int DATA_W     = 32;
  localparam int EXP_W      = 5;
  localparam int EXP_IDX_W  = $clog2(EXP_W);
  localparam int IN_FIELD_W = DATA_W + EXP_W;
  localparam int IN_TDATA_W = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 7) / 8) * 8;

  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [EXP_W-1:0]  expo;
    logic [DATA_W-1:0] acc;
  } ipu_item_t;

endpackage

@@ rtl/integer_power_unit.sv @@
// Throughput: one beat per cycle unless the output stalls; eight registered 32x32
// low-half multiplies (square, then conditional multiply, for exponent bits
// 3..0) set the depth. Each stage holds only while its successor is full, so
// bubbles collapse. Reset (rst, synchronous) empties every stage; payload is not cleared.
// ----------------------------------------------------------------------------
// Integer power unit
// Signed base raised to a 5-bit exponent by pipelined square-and-multiply,
// wrapping modulo two to the data width.
// ----------------------------------------------------------------------------
module integer_power_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ipu_pkg::IN_TDATA_W-1:0] s_tdata,  // base[31:0], exponent[36:32], zero pad
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ipu_pkg::OUT_TDATA_W-1:0] m_tdata  // power[31:0]
);
  import ipu_pkg::*;

  localparam int NUM_MUL = 2 * (EXP_W - 1);
  localparam int NUM_STG = NUM_MUL + 1;

  ipu_item_t stg [NUM_STG];
  logic      vld [NUM_STG];
  logic      en  [NUM_STG];

  logic [DATA_W-1:0] in_base;
  logic [EXP_W-1:0]  in_expo;

  assign in_base = s_tdata[DATA_W-1:0];
  assign in_expo = s_tdata[IN_FIELD_W-1:DATA_W];

  always_comb begin
    en[NUM_STG-1] = !vld[NUM_STG-1] || m_tready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  // top exponent bit: squaring 1 is a no-op, so only the base select remains
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en[0]) begin
      vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stg[0].base <= in_base;
      stg[0].expo <= in_expo;
      stg[0].acc  <= in_expo[EXP_W-1] ? in_base : DATA_W'(1);
    end
  end

  for (genvar j = 0; j < NUM_MUL; j++) begin : g_mul
    ipu_mul_stage #(
      .SQUARE  ((j % 2) == 0),
      .BIT_IDX (EXP_W - 2 - (j / 2))
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en[j+1]),
      .in_vld   (vld[j]),
      .in_item  (stg[j]),
      .out_vld  (vld[j+1]),
      .out_item (stg[j+1])
    );
  end

  assign m_tvalid = vld[NUM_STG-1];
  assign m_tdata  = OUT_TDATA_W'(stg[NUM_STG-1].acc);

endmodule

@@ rtl/ipu_mul_stage.sv @@
// ----------------------------------------------------------------------------
// Integer power unit multiply stage
// One registered wrapping multiply: squares the running result, or
// multiplies it by the base when the selected exponent bit is set.
// ----------------------------------------------------------------------------
module ipu_mul_stage #(
  parameter bit SQUARE  = 1'b1,
  parameter int BIT_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  ipu_pkg::ipu_item_t in_item,
  output logic               out_vld,
  output ipu_pkg::ipu_item_t out_item
);
  import ipu_pkg::*;

  localparam logic [EXP_IDX_W-1:0] BIT_SEL = BIT_IDX[EXP_IDX_W-1:0];

  logic              sel;
  logic [DATA_W-1:0] operand;
  logic [DATA_W-1:0] prod;

  assign sel     = SQUARE ? 1'b1 : in_item.expo[BIT_SEL];
  assign operand = SQUARE ? in_item.acc : in_item.base;
  assign prod    = in_item.acc * operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.base <= in_item.base;
      out_item.expo <= in_item.expo;
      out_item.acc  <= sel ? prod : in_item.acc;
    end
  end

endmodule

@@ rtl/ipu_checker.sv @@
// ----------------------------------------------------------------------------
// Integer power unit port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "integer_power_unit_macros.svh"

module ipu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ipu_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // output register held under backpressure
  `IPU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

  // a drained or draining output never blocks the input side
  `IPU_ASSERT_NOW(a_in_ready, !m_tvalid || m_tready, s_tready, "input stalled with output free")

  // reset empties the pipeline
  `IPU_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !m_tvalid, "output valid right after reset")

  // after reset, nothing reaches the output before a beat has crossed every stage
  `IPU_ASSERT_NEXT_ALWAYS(a_no_bypass, rst, !m_tvalid [*8], "result appeared without pipeline delay")

endmodule

bind integer_power_unit ipu_checker u_ipu_checker (.*);
